// ===== hdl/canonical_line_discipline_core_macros.svh =====
// Assertion macros for the canonical line discipline core.
// No dependencies; included by the files that carry assertions.
`ifndef CANONICAL_LINE_DISCIPLINE_CORE_MACROS_SVH
`define CANONICAL_LINE_DISCIPLINE_CORE_MACROS_SVH
`ifndef SYNTHESIS
// Concurrent assertion on an explicit clock and active-low reset
`define CLD_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Concurrent assertion on the block clock and reset
`define CLD_ASSERT(lbl, prop, msg) `CLD_ASSERT_CLK(lbl, aclk, aresetn, prop, msg)
`else
`define CLD_ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define CLD_ASSERT(lbl, prop, msg)
`endif
`endif

// ===== hdl/cld_pkg.sv =====
// Shared types and constants for the canonical line discipline core.
// No dependencies.
package cld_pkg;

    // Sizes
    localparam int DEFAULT_DEPTH = 256;
    localparam int BYTE_W        = 8;
    localparam int COUNT_OUT_W   = 9;
    localparam int CFG_IDX_W     = 3;

    // Characters
    localparam logic [BYTE_W-1:0] CHAR_NL = 8'd10;
    localparam logic [BYTE_W-1:0] CHAR_CR = 8'd13;
    localparam logic [BYTE_W-1:0] CHAR_BS = 8'd8;
    localparam logic [BYTE_W-1:0] CHAR_SP = 8'd32;

    // Line count saturates here
    localparam logic [COUNT_OUT_W-1:0] LINE_MAX = 9'd511;

    // Operations
    localparam logic OP_RECV = 1'b0;
    localparam logic OP_POP  = 1'b1;

    // Result kinds
    localparam logic [1:0] KIND_ECHO = 2'd0;
    localparam logic [1:0] KIND_READ = 2'd1;
    localparam logic [1:0] KIND_NONE = 2'd2;
    localparam logic [1:0] KIND_DROP = 2'd3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NL_TO_CR = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CR_TO_NL = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IGN_CR   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ECHO     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ECHO_NL  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_EOL      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_ERASE    = 3'd6;

    typedef struct packed {
        logic              operation;
        logic [BYTE_W-1:0] in_byte;
    } in_item_t;

    typedef struct packed {
        logic [1:0]             out_kind;
        logic [BYTE_W-1:0]      out_byte;
        logic                   line_end;
        logic                   last;
        logic [COUNT_OUT_W-1:0] fill_count;
        logic [COUNT_OUT_W-1:0] lines_ready;
    } out_item_t;

    typedef struct packed {
        logic              nl_to_cr_en;
        logic              cr_to_nl_en;
        logic              ignore_cr_en;
        logic              echo_en;
        logic              echo_nl_en;
        logic [BYTE_W-1:0] eol_char;
        logic [BYTE_W-1:0] erase_char;
    } cfg_t;

    // One pending result before counts are attached
    typedef struct packed {
        logic [1:0]        kind;
        logic [BYTE_W-1:0] data;
        logic              le;
    } res_entry_t;

    localparam cfg_t CFG_RESET = '{
        nl_to_cr_en:  1'b0,
        cr_to_nl_en:  1'b1,
        ignore_cr_en: 1'b0,
        echo_en:      1'b1,
        echo_nl_en:   1'b0,
        eol_char:     8'd10,
        erase_char:   8'd8
    };

endpackage

// ===== hdl/cld_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module cld_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/cld_cfg.sv =====
// Configuration register file for the line discipline.
// Depends on cld_pkg.
module cld_cfg (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [cld_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cld_pkg::BYTE_W-1:0]     cfg_wdata,
    output cld_pkg::cfg_t                  cfg
);

    cld_pkg::cfg_t cfg_reg;
    cld_pkg::cfg_t cfg_next;

    // Decode the write; unknown indexes change nothing
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_index)
                cld_pkg::CFG_NL_TO_CR: cfg_next.nl_to_cr_en  = cfg_wdata[0];
                cld_pkg::CFG_CR_TO_NL: cfg_next.cr_to_nl_en  = cfg_wdata[0];
                cld_pkg::CFG_IGN_CR:   cfg_next.ignore_cr_en = cfg_wdata[0];
                cld_pkg::CFG_ECHO:     cfg_next.echo_en      = cfg_wdata[0];
                cld_pkg::CFG_ECHO_NL:  cfg_next.echo_nl_en   = cfg_wdata[0];
                cld_pkg::CFG_EOL:      cfg_next.eol_char     = cfg_wdata;
                cld_pkg::CFG_ERASE:    cfg_next.erase_char   = cfg_wdata;
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= cld_pkg::CFG_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== hdl/cld_ctrl.sv =====
// Line editor sequencer: ring pointers, counts, read-modify-write of the
// byte store, and the result queue. Depends on cld_pkg and the macro header.
`include "canonical_line_discipline_core_macros.svh"

module cld_ctrl #(
    parameter int BUFFER_DEPTH = cld_pkg::DEFAULT_DEPTH,
    localparam int PTR_W = $clog2(BUFFER_DEPTH),
    localparam int CNT_W = $clog2(BUFFER_DEPTH + 1)
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  cld_pkg::cfg_t               cfg,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  cld_pkg::in_item_t           s_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output cld_pkg::out_item_t          m_data,
    output logic                        mem_we,
    output logic [PTR_W-1:0]            mem_waddr,
    output logic [cld_pkg::BYTE_W-1:0]  mem_wdata,
    output logic                        mem_re,
    output logic [PTR_W-1:0]            mem_raddr,
    input  logic [cld_pkg::BYTE_W-1:0]  mem_rdata
);

    localparam int FW = cld_pkg::COUNT_OUT_W;

    // Sequencer states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(BUFFER_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(BUFFER_DEPTH);

    logic [1:0]          state_reg,   state_next;
    logic [PTR_W-1:0]    wr_pos_reg,  wr_pos_next;
    logic [PTR_W-1:0]    rd_pos_reg,  rd_pos_next;
    logic [CNT_W-1:0]    count_reg,   count_next;
    logic [FW-1:0]       lines_reg,   lines_next;
    logic                pop_pend_reg, pop_pend_next;
    cld_pkg::res_entry_t res_reg [3];
    cld_pkg::res_entry_t res_next [3];
    logic [1:0]          res_n_reg,   res_n_next;
    logic [1:0]          res_idx_reg, res_idx_next;
    logic                m_valid_reg, m_valid_next;
    cld_pkg::out_item_t  m_data_reg,  m_data_next;

    logic                  accept;
    logic [cld_pkg::BYTE_W-1:0] xl_byte;
    logic                  xl_drop;
    logic                  is_erase;
    logic                  echo;
    logic                  full;
    logic                  empty;
    logic                  out_free;
    logic                  rd_le;
    logic                  res_last;
    logic [PTR_W-1:0]      wr_pos_inc;
    logic [PTR_W-1:0]      wr_pos_dec;
    logic [PTR_W-1:0]      rd_pos_inc;
    cld_pkg::res_entry_t   echo_ent;
    cld_pkg::res_entry_t   drop_ent;
    cld_pkg::res_entry_t   cur_ent;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // Receive translation: NL->CR, CR->NL, or discard CR
    always_comb begin
        xl_byte = s_data.in_byte;
        xl_drop = 1'b0;
        if (s_data.in_byte == cld_pkg::CHAR_NL && cfg.nl_to_cr_en) begin
            xl_byte = cld_pkg::CHAR_CR;
        end else if (s_data.in_byte == cld_pkg::CHAR_CR && cfg.cr_to_nl_en) begin
            xl_byte = cld_pkg::CHAR_NL;
        end else if (s_data.in_byte == cld_pkg::CHAR_CR && cfg.ignore_cr_en) begin
            xl_drop = 1'b1;
        end
    end

    assign is_erase = (xl_byte == cfg.erase_char);
    assign echo     = cfg.echo_en || (xl_byte == cld_pkg::CHAR_NL && cfg.echo_nl_en);
    assign full     = (count_reg == CNT_FULL);
    assign empty    = (count_reg == '0);
    assign rd_le    = (mem_rdata == cfg.eol_char);

    // Ring pointer arithmetic, wrapping at any depth
    assign wr_pos_inc = (wr_pos_reg == PTR_LAST) ? '0 : wr_pos_reg + 1'b1;
    assign wr_pos_dec = (wr_pos_reg == '0) ? PTR_LAST : wr_pos_reg - 1'b1;
    assign rd_pos_inc = (rd_pos_reg == PTR_LAST) ? '0 : rd_pos_reg + 1'b1;

    assign echo_ent = '{kind: cld_pkg::KIND_ECHO, data: xl_byte, le: 1'b0};
    assign drop_ent = '{kind: cld_pkg::KIND_DROP, data: xl_byte, le: 1'b0};
    assign cur_ent  = res_reg[res_idx_reg];
    assign res_last = (res_idx_reg == res_n_reg - 2'd1);

    // Sequencer. Store writes happen only on a receive accept and reads only
    // on a pop or erase accept, so a write and a read never share a cycle and
    // a read always sees the data written by an earlier item.
    always_comb begin
        state_next    = state_reg;
        wr_pos_next   = wr_pos_reg;
        rd_pos_next   = rd_pos_reg;
        count_next    = count_reg;
        lines_next    = lines_reg;
        pop_pend_next = pop_pend_reg;
        res_next      = res_reg;
        res_n_next    = res_n_reg;
        res_idx_next  = res_idx_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_data_next   = m_data_reg;
        mem_we        = 1'b0;
        mem_waddr     = wr_pos_reg;
        mem_wdata     = xl_byte;
        mem_re        = 1'b0;
        mem_raddr     = rd_pos_reg;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    res_idx_next = 2'd0;
                    if (s_data.operation == cld_pkg::OP_POP) begin
                        if (lines_reg == '0 || empty) begin
                            res_next[0] = '{kind: cld_pkg::KIND_NONE, data: '0, le: 1'b0};
                            res_n_next  = 2'd1;
                            state_next  = ST_EMIT;
                        end else begin
                            mem_re        = 1'b1;
                            mem_raddr     = rd_pos_reg;
                            pop_pend_next = 1'b1;
                            state_next    = ST_READ;
                        end
                    end else if (!xl_drop) begin
                        if (is_erase) begin
                            // Fetch the newest byte to see if it ends a line
                            if (!empty) begin
                                mem_re        = 1'b1;
                                mem_raddr     = wr_pos_dec;
                                pop_pend_next = 1'b0;
                                state_next    = ST_READ;
                            end
                        end else begin
                            if (!full) begin
                                mem_we      = 1'b1;
                                wr_pos_next = wr_pos_inc;
                                count_next  = count_reg + 1'b1;
                                if (xl_byte == cfg.eol_char && lines_reg < cld_pkg::LINE_MAX) begin
                                    lines_next = lines_reg + 1'b1;
                                end
                            end
                            res_next[0] = echo ? echo_ent : drop_ent;
                            res_next[1] = drop_ent;
                            res_n_next  = {1'b0, echo} + {1'b0, full};
                            if (echo || full) begin
                                state_next = ST_EMIT;
                            end
                        end
                    end
                end
            end
            ST_READ: begin
                res_idx_next = 2'd0;
                if (pop_pend_reg) begin
                    rd_pos_next = rd_pos_inc;
                    count_next  = count_reg - 1'b1;
                    if (rd_le && lines_reg != '0) begin
                        lines_next = lines_reg - 1'b1;
                    end
                    res_next[0] = '{kind: cld_pkg::KIND_READ, data: mem_rdata, le: rd_le};
                    res_n_next  = 2'd1;
                    state_next  = ST_EMIT;
                end else if (rd_le) begin
                    // Erase never crosses a line end
                    state_next = ST_IDLE;
                end else begin
                    wr_pos_next = wr_pos_dec;
                    count_next  = count_reg - 1'b1;
                    res_next[0] = '{kind: cld_pkg::KIND_ECHO, data: cld_pkg::CHAR_BS, le: 1'b0};
                    res_next[1] = '{kind: cld_pkg::KIND_ECHO, data: cld_pkg::CHAR_SP, le: 1'b0};
                    res_next[2] = '{kind: cld_pkg::KIND_ECHO, data: cld_pkg::CHAR_BS, le: 1'b0};
                    res_n_next  = 2'd3;
                    state_next  = ST_EMIT;
                end
            end
            ST_EMIT: begin
                // One queued result per free output slot, counts attached
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = '{
                        out_kind:    cur_ent.kind,
                        out_byte:    cur_ent.data,
                        line_end:    cur_ent.le,
                        last:        res_last,
                        fill_count:  FW'(count_reg),
                        lines_ready: lines_reg
                    };
                    res_idx_next = res_idx_reg + 2'd1;
                    if (res_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            wr_pos_reg   <= '0;
            rd_pos_reg   <= '0;
            count_reg    <= '0;
            lines_reg    <= '0;
            pop_pend_reg <= 1'b0;
            res_n_reg    <= 2'd0;
            res_idx_reg  <= 2'd0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            wr_pos_reg   <= wr_pos_next;
            rd_pos_reg   <= rd_pos_next;
            count_reg    <= count_next;
            lines_reg    <= lines_next;
            pop_pend_reg <= pop_pend_next;
            res_n_reg    <= res_n_next;
            res_idx_reg  <= res_idx_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Checks
    `CLD_ASSERT(a_count_bound, count_reg <= CNT_FULL, "byte count above buffer depth")
    `CLD_ASSERT(a_mem_port_excl, !(mem_we && mem_re), "store read and write in one cycle")
    `CLD_ASSERT(a_read_follows_req, (state_reg == ST_READ) |-> $past(mem_re), "read state without a store read")
    `CLD_ASSERT(a_count_step, $past(aresetn) |-> (count_reg == $past(count_reg) || count_reg == $past(count_reg) + 1'b1 || count_reg == $past(count_reg) - 1'b1), "byte count moved by more than one")
    `CLD_ASSERT(a_last_ends_item, (state_reg == ST_EMIT && out_free && res_last) |=> (state_reg == ST_IDLE), "item not closed after its final word")

endmodule

// ===== hdl/canonical_line_discipline_core.sv =====
// Canonical terminal line discipline: receive path edits a line in a byte
// ring, pop path hands whole lines to a reader.
// Input channel s_*: operation 0 receives s_data.in_byte, 1 pops one byte.
// Result channel m_*: zero to three words per input word; the final one has
// last set and every word carries the byte and line counts after that item.
// Configuration: cfg_we/cfg_index/cfg_wdata write one register per cycle.
// Timing: a word is taken only while the sequencer is idle. A receive that
// yields no result, other than an erase stopped at a line end, leaves the
// sequencer idle (one word per cycle). A receive with echo or drop moves to
// the emit state, which puts its results in the output register; pop and
// erase first pass through the read state for the registered store read.
// The emit state places one result per free output slot.
// Stall: a held output word blocks the item's remaining results, and the
// input with them, since the sequencer waits in its emit state until the
// output register frees; once the final word is placed, the next input is
// taken even while that word is still held.
// Reset (aresetn low, synchronous): pointers and counts clear, registers
// take their defaults; the store needs no clearing pass.
module canonical_line_discipline_core #(
    parameter int BUFFER_DEPTH = cld_pkg::DEFAULT_DEPTH
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  cld_pkg::in_item_t              s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output cld_pkg::out_item_t             m_data,
    input  logic                           cfg_we,
    input  logic [cld_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cld_pkg::BYTE_W-1:0]     cfg_wdata
);

    localparam int PTR_W = $clog2(BUFFER_DEPTH);

    cld_pkg::cfg_t              cfg;
    logic                       mem_we;
    logic [PTR_W-1:0]           mem_waddr;
    logic [cld_pkg::BYTE_W-1:0] mem_wdata;
    logic                       mem_re;
    logic [PTR_W-1:0]           mem_raddr;
    logic [cld_pkg::BYTE_W-1:0] mem_rdata;

    // Register file
    cld_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // Byte ring store
    cld_ram #(
        .WIDTH (cld_pkg::BYTE_W),
        .DEPTH (BUFFER_DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Sequencer
    cld_ctrl #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for canonical_line_discipline_core: drives receive and pop words,
// predicts every echo, read, no-line and drop word, and checks them in order.
// Depends on cld_pkg and the core RTL only.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH          = cld_pkg::DEFAULT_DEPTH;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 10;
    localparam int RANDOM_WORDS   = 16;
    // Index with no register behind it; writes to it must be ignored
    localparam logic [cld_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

    // Tracks ring contents, counts and registers; predicts result words
    class tty_line_tracker;
        logic [cld_pkg::BYTE_W-1:0] ring [DEPTH];
        int unsigned                rd_ptr, wr_ptr, held, lines;
        cld_pkg::cfg_t              regs;
        cld_pkg::out_item_t         expected_words [$];
        int unsigned                bad_words;

        function new();
            regs      = cld_pkg::CFG_RESET;
            rd_ptr    = 0;
            wr_ptr    = 0;
            held      = 0;
            lines     = 0;
            bad_words = 0;
        endfunction

        function void write_reg(logic [cld_pkg::CFG_IDX_W-1:0] idx,
                                logic [cld_pkg::BYTE_W-1:0] val);
            case (idx)
                cld_pkg::CFG_NL_TO_CR: regs.nl_to_cr_en  = val[0];
                cld_pkg::CFG_CR_TO_NL: regs.cr_to_nl_en  = val[0];
                cld_pkg::CFG_IGN_CR:   regs.ignore_cr_en = val[0];
                cld_pkg::CFG_ECHO:     regs.echo_en      = val[0];
                cld_pkg::CFG_ECHO_NL:  regs.echo_nl_en   = val[0];
                cld_pkg::CFG_EOL:      regs.eol_char     = val;
                cld_pkg::CFG_ERASE:    regs.erase_char   = val;
                default: ;
            endcase
        endfunction

        function void predict_input(cld_pkg::in_item_t w);
            cld_pkg::res_entry_t        res [$];
            logic [cld_pkg::BYTE_W-1:0] c;
            logic                       le;
            int unsigned                prev;
            cld_pkg::out_item_t         o;

            if (w.operation == cld_pkg::OP_POP) begin
                if (lines == 0 || held == 0) begin
                    res.push_back(cld_pkg::res_entry_t'{cld_pkg::KIND_NONE, 8'd0, 1'b0});
                end else begin
                    c      = ring[rd_ptr];
                    le     = (c == regs.eol_char);
                    rd_ptr = (rd_ptr + 1) % DEPTH;
                    held--;
                    if (le && lines > 0) lines--;
                    res.push_back(cld_pkg::res_entry_t'{cld_pkg::KIND_READ, c, le});
                end
            end else begin
                c = w.in_byte;
                // Line-ending translation ahead of editing
                if (c == cld_pkg::CHAR_NL && regs.nl_to_cr_en) c = cld_pkg::CHAR_CR;
                else if (c == cld_pkg::CHAR_CR && regs.cr_to_nl_en) c = cld_pkg::CHAR_NL;
                else if (c == cld_pkg::CHAR_CR && regs.ignore_cr_en) return;

                if (c == regs.erase_char) begin
                    if (held == 0) return;
                    prev = (wr_ptr + DEPTH - 1) % DEPTH;
                    // A finished line cannot be edited
                    if (ring[prev] == regs.eol_char) return;
                    wr_ptr = prev;
                    held--;
                    res.push_back(cld_pkg::res_entry_t'{cld_pkg::KIND_ECHO,
                                                        cld_pkg::CHAR_BS, 1'b0});
                    res.push_back(cld_pkg::res_entry_t'{cld_pkg::KIND_ECHO,
                                                        cld_pkg::CHAR_SP, 1'b0});
                    res.push_back(cld_pkg::res_entry_t'{cld_pkg::KIND_ECHO,
                                                        cld_pkg::CHAR_BS, 1'b0});
                end else begin
                    if (regs.echo_en || (c == cld_pkg::CHAR_NL && regs.echo_nl_en))
                        res.push_back(cld_pkg::res_entry_t'{cld_pkg::KIND_ECHO, c, 1'b0});
                    if (held >= DEPTH) begin
                        res.push_back(cld_pkg::res_entry_t'{cld_pkg::KIND_DROP, c, 1'b0});
                    end else begin
                        ring[wr_ptr] = c;
                        wr_ptr       = (wr_ptr + 1) % DEPTH;
                        held++;
                        if (c == regs.eol_char && lines < cld_pkg::LINE_MAX) lines++;
                    end
                end
            end

            // Every word of this item carries the counts after the item
            foreach (res[k]) begin
                o.out_kind    = res[k].kind;
                o.out_byte    = res[k].data;
                o.line_end    = res[k].le;
                o.last        = (k == res.size() - 1);
                o.fill_count  = cld_pkg::COUNT_OUT_W'(held);
                o.lines_ready = cld_pkg::COUNT_OUT_W'(lines);
                expected_words.push_back(o);
            end
        endfunction

        function void check_word(cld_pkg::out_item_t got);
            cld_pkg::out_item_t exp_w;

            if (expected_words.size() == 0) begin
                bad_words++;
                if (bad_words <= 10)
                    $display("%0t: unexpected word kind=%0d byte=%02h le=%0b last=%0b",
                             $realtime, got.out_kind, got.out_byte, got.line_end, got.last);
                return;
            end
            exp_w = expected_words.pop_front();
            if (got.out_kind !== exp_w.out_kind || got.out_byte !== exp_w.out_byte ||
                got.line_end !== exp_w.line_end || got.last !== exp_w.last ||
                got.fill_count !== exp_w.fill_count ||
                got.lines_ready !== exp_w.lines_ready) begin
                bad_words++;
                if (bad_words <= 10) begin
                    $display("%0t: mismatch exp kind=%0d byte=%02h le=%0b last=%0b fill=%0d lines=%0d",
                             $realtime,
                             exp_w.out_kind, exp_w.out_byte, exp_w.line_end, exp_w.last,
                             exp_w.fill_count, exp_w.lines_ready);
                    $display("    got kind=%0d byte=%02h le=%0b last=%0b fill=%0d lines=%0d",
                             got.out_kind, got.out_byte, got.line_end, got.last,
                             got.fill_count, got.lines_ready);
                end
            end
        endfunction
    endclass

    logic                           aclk      = 1'b0;
    logic                           aresetn   = 1'b0;
    logic                           s_valid   = 1'b0;
    logic                           s_ready;
    cld_pkg::in_item_t              s_data    = '0;
    logic                           m_valid;
    logic                           m_ready   = 1'b0;
    cld_pkg::out_item_t             m_data;
    logic                           cfg_we    = 1'b0;
    logic [cld_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [cld_pkg::BYTE_W-1:0]     cfg_wdata = '0;

    int unsigned     send_idle_pct = 0;
    int unsigned     stall_pct     = 0;
    logic            hold_tgl      = 1'b0;
    logic            hold_seen     = 1'b0;
    int unsigned     hold_left     = 0;
    int unsigned     quiet_cycles  = 0;
    tty_line_tracker model         = new();

    canonical_line_discipline_core #(
        .BUFFER_DEPTH(DEPTH)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #1 aclk = ~aclk;

    // Result side: random stalls, plus a long hold-off on request
    always @(posedge aclk) begin
        if (hold_tgl != hold_seen) begin
            hold_seen <= hold_tgl;
            hold_left <= HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Check results before noting new input; an item's words never leave on its own edge
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) model.check_word(m_data);
        if (aresetn && s_valid && s_ready) model.predict_input(s_data);
        if (!aresetn || (m_valid && m_ready) || (s_valid && s_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic cld_pkg::in_item_t rx_word(logic [cld_pkg::BYTE_W-1:0] b);
        return cld_pkg::in_item_t'{cld_pkg::OP_RECV, b};
    endfunction

    // Byte field is don't-care for pops, so randomize it anyway
    function automatic cld_pkg::in_item_t pop_word();
        return cld_pkg::in_item_t'{cld_pkg::OP_POP, cld_pkg::BYTE_W'($urandom)};
    endfunction

    // Mostly line-shaped traffic: text, line ends, erases, pops
    function automatic cld_pkg::in_item_t random_word();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 30) return pop_word();
        if (r < 45) return rx_word(model.regs.eol_char);
        if (r < 55) return rx_word(model.regs.erase_char);
        if (r < 62) return rx_word(r[0] ? cld_pkg::CHAR_CR : cld_pkg::CHAR_NL);
        return rx_word(cld_pkg::BYTE_W'($urandom));
    endfunction

    function automatic cld_pkg::cfg_t random_cfg();
        return cld_pkg::cfg_t'($urandom);
    endfunction

    task automatic set_pace(int unsigned idle_pct, int unsigned stall_in);
        send_idle_pct = idle_pct;
        stall_pct     = stall_in;
    endtask

    task automatic send_word(cld_pkg::in_item_t w);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Wait for every expected word, then let a busy sequencer finish
    task automatic wait_quiet();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (model.expected_words.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Write all registers (1-bit ones with junk upper bits) and the unused index
    task automatic load_regs(cld_pkg::cfg_t c);
        logic [cld_pkg::CFG_IDX_W-1:0] idx  [8];
        logic [cld_pkg::BYTE_W-1:0]    vals [8];
        idx  = '{cld_pkg::CFG_NL_TO_CR, cld_pkg::CFG_CR_TO_NL, cld_pkg::CFG_IGN_CR,
                 cld_pkg::CFG_ECHO, cld_pkg::CFG_ECHO_NL, cld_pkg::CFG_EOL,
                 cld_pkg::CFG_ERASE, CFG_UNUSED};
        vals = '{{7'($urandom), c.nl_to_cr_en}, {7'($urandom), c.cr_to_nl_en},
                 {7'($urandom), c.ignore_cr_en}, {7'($urandom), c.echo_en},
                 {7'($urandom), c.echo_nl_en}, c.eol_char, c.erase_char,
                 cld_pkg::BYTE_W'($urandom)};
        for (int i = 0; i < 8; i++) begin
            cfg_we    <= 1'b1;
            cfg_index <= idx[i];
            cfg_wdata <= vals[i];
            @(posedge aclk);
            model.write_reg(idx[i], vals[i]);
        end
        cfg_we <= 1'b0;
    endtask

    initial begin
        cld_pkg::cfg_t              c;
        logic [cld_pkg::BYTE_W-1:0] free_byte;
        logic                       hit;
        int unsigned                held_now;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Defaults: pops with no line ready, erase on empty, extremes, erase
        // echo, CR turned into a line end, erase stopped at the line end
        send_word(pop_word());
        send_word(rx_word(cld_pkg::CHAR_BS));
        send_word(rx_word(8'h61));
        send_word(rx_word(8'h00));
        send_word(rx_word(8'hFF));
        send_word(pop_word());
        send_word(rx_word(cld_pkg::CHAR_BS));
        send_word(rx_word(cld_pkg::CHAR_CR));
        send_word(rx_word(cld_pkg::CHAR_BS));
        repeat (4) send_word(pop_word());
        wait_quiet();

        // CR dropped, NL to CR, silent queueing, erase echo with echo off
        c = cld_pkg::CFG_RESET;
        c.nl_to_cr_en  = 1'b1;
        c.cr_to_nl_en  = 1'b0;
        c.ignore_cr_en = 1'b1;
        c.echo_en      = 1'b0;
        c.echo_nl_en   = 1'b1;
        load_regs(c);
        send_word(rx_word(cld_pkg::CHAR_CR));
        send_word(rx_word(cld_pkg::CHAR_NL));
        send_word(rx_word(cld_pkg::CHAR_BS));
        send_word(rx_word(8'h41));
        wait_quiet();

        // Newline echo alone, CR as line end
        c.nl_to_cr_en  = 1'b0;
        c.ignore_cr_en = 1'b0;
        c.eol_char     = cld_pkg::CHAR_CR;
        c.erase_char   = 8'h7F;
        load_regs(c);
        send_word(rx_word(cld_pkg::CHAR_NL));
        send_word(rx_word(cld_pkg::CHAR_CR));
        repeat (3) send_word(pop_word());
        wait_quiet();

        // Random phases under different idling; the first one also drives
        // the core while the result side holds off
        for (int ph = 0; ph < 4; ph++) begin
            c = random_cfg();
            case (ph)
                0: begin
                    set_pace(0, 0);
                    c.echo_en    = 1'b1;
                    c.eol_char   = 8'h00;
                    c.erase_char = 8'hFF;
                end
                1: begin
                    set_pace(58, 0);
                    c.eol_char   = 8'hFF;
                    c.erase_char = 8'h00;
                end
                2: set_pace(0, 58);
                default: set_pace(24, 24);
            endcase
            load_regs(c);
            if (ph == 0) hold_tgl <= ~hold_tgl;
            repeat (RANDOM_WORDS) send_word(random_word());
            wait_quiet();
        end

        // Empty the ring by erasing, using a line end that no held byte matches
        set_pace(24, 24);
        free_byte = 8'h00;
        for (int v = 0; v < 256; v++) begin
            hit = 1'b0;
            for (int j = 0; j < model.held; j++)
                if (model.ring[(model.rd_ptr + j) % DEPTH] == cld_pkg::BYTE_W'(v)) hit = 1'b1;
            if (!hit) free_byte = cld_pkg::BYTE_W'(v);
        end
        c = cld_pkg::CFG_RESET;
        c.cr_to_nl_en = 1'b0;
        c.echo_en     = 1'b0;
        c.eol_char    = free_byte;
        c.erase_char  = ~free_byte;
        load_regs(c);
        held_now = model.held;
        repeat (held_now) send_word(rx_word(~free_byte));

        // Fill with line ends, then overflow with and without echo
        repeat (DEPTH + 1) send_word(rx_word(free_byte));
        wait_quiet();
        c.echo_en = 1'b1;
        load_regs(c);
        send_word(rx_word(free_byte));
        wait_quiet();

        if (model.bad_words == 0 && model.expected_words.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/cld_pkg.sv
hdl/cld_ram.sv
hdl/cld_cfg.sv
hdl/cld_ctrl.sv
hdl/canonical_line_discipline_core.sv
dv/testbench.sv
